// ===== hw/rtl/b2da_pkg.sv =====
package b2da_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned COUNT_W = 4;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic trim;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic bit_last;
        logic top_zero;
        logic ndig_one;
        logic left_one;
    } t_dp_sts;

endpackage

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
// The double-dabble shifts walk all VALUE_BITS input bits, then leading zero digits are dropped
// (at least one digit stays) and the trim state settles; the digits then come out most significant
// first, ND = max digits (10 at 32 bits). The single shared shift-and-add-3 unit walks one bit a
// cycle, and a new value is accepted only in idle, once the last digit is out; reset is
// synchronous active-low and returns the controller to idle. Digits come out as one-cycle
// strobes; no stall possible.
module binary_to_decimal_ascii_unit #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_BITS-1:0]        i_value,
    output logic                         o_busy,
    output logic                         o_digit_valid,
    output logic [b2da_pkg::CHAR_W-1:0]  o_digit_char,
    output logic [b2da_pkg::COUNT_W-1:0] o_digit_count,
    output logic                         o_last_digit
);

    b2da_pkg::t_dp_cmd cmd;
    b2da_pkg::t_dp_sts sts;

    b2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    b2da_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_last_digit  (o_last_digit)
    );

    assign o_digit_valid = cmd.emit;

endmodule

// ===== hw/rtl/b2da_ctrl.sv =====
module b2da_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  b2da_pkg::t_dp_sts i_sts,
    output b2da_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);

    b2da_pkg::t_state r_state;
    b2da_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2da_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            b2da_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = b2da_pkg::ST_CONVERT;
                end
            end
            b2da_pkg::ST_CONVERT: begin
                if (i_sts.bit_last) begin
                    n_state = b2da_pkg::ST_TRIM;
                end
            end
            b2da_pkg::ST_TRIM: begin
                if (!i_sts.top_zero || i_sts.ndig_one) begin
                    n_state = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT: begin
                if (i_sts.left_one) begin
                    n_state = b2da_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            b2da_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            b2da_pkg::ST_CONVERT: begin
                o_cmd.dabble = 1'b1;
            end
            b2da_pkg::ST_TRIM: begin
                o_cmd.trim = i_sts.top_zero && !i_sts.ndig_one;
            end
            b2da_pkg::ST_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/b2da_dp.sv =====
module b2da_dp #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [VALUE_BITS-1:0]          i_value,
    input  b2da_pkg::t_dp_cmd              i_cmd,
    output b2da_pkg::t_dp_sts              o_sts,
    output logic [b2da_pkg::CHAR_W-1:0]    o_digit_char,
    output logic [b2da_pkg::COUNT_W-1:0]   o_digit_count,
    output logic                           o_last_digit
);

    localparam int unsigned ND        = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int unsigned BCD_W     = ND * b2da_pkg::DIGIT_W;
    localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int unsigned DIG_CNT_W = $clog2(ND + 1);
    localparam int unsigned DW        = b2da_pkg::DIGIT_W;

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [DIG_CNT_W-1:0]  r_ndig;
    logic [DIG_CNT_W-1:0]  r_left;
    logic [BCD_W-1:0]      adj_bcd;
    logic [DW-1:0]         top_digit;

    always_comb begin
        for (int i = 0; i < ND; i++) begin
            if (r_bcd[i*DW +: DW] >= b2da_pkg::DABBLE_MIN) begin
                adj_bcd[i*DW +: DW] = r_bcd[i*DW +: DW] + b2da_pkg::DABBLE_ADD;
            end else begin
                adj_bcd[i*DW +: DW] = r_bcd[i*DW +: DW];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: DW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= i_value;
            r_bcd     <= '0;
            r_bit_cnt <= BIT_CNT_W'(VALUE_BITS);
            r_ndig    <= DIG_CNT_W'(ND);
            r_left    <= DIG_CNT_W'(ND);
        end else if (i_cmd.dabble) begin
            r_bcd     <= {adj_bcd[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin     <= r_bin << 1;
            r_bit_cnt <= r_bit_cnt - BIT_CNT_W'(1);
        end else if (i_cmd.trim) begin
            r_bcd  <= r_bcd << DW;
            r_ndig <= r_ndig - DIG_CNT_W'(1);
            r_left <= r_left - DIG_CNT_W'(1);
        end else if (i_cmd.emit) begin
            r_bcd  <= r_bcd << DW;
            r_left <= r_left - DIG_CNT_W'(1);
        end
    end

    assign o_sts.bit_last = (r_bit_cnt == BIT_CNT_W'(1));
    assign o_sts.top_zero = (top_digit == '0);
    assign o_sts.ndig_one = (r_ndig == DIG_CNT_W'(1));
    assign o_sts.left_one = (r_left == DIG_CNT_W'(1));

    assign o_digit_char  = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(top_digit);
    assign o_digit_count = b2da_pkg::COUNT_W'(r_ndig);
    assign o_last_digit  = (r_left == DIG_CNT_W'(1));

    a_emit_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (top_digit <= 4'd9))
        else $error("emitted digit out of decimal range");

    a_emit_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_left != '0))
        else $error("emit with no digits left");

    a_trim_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.trim |-> (o_sts.top_zero && !o_sts.ndig_one))
        else $error("trim dropped a significant digit");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_last_digit) |=> !i_cmd.emit)
        else $error("emit continued past last digit");

    a_load_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_bit_cnt == BIT_CNT_W'(VALUE_BITS)))
        else $error("bit counter not loaded");

endmodule
